/* rtl/core/ait_pkg.sv */
// shared types and constants for the accelerometer impact trigger
`timescale 1ns / 1ps

package ait_pkg;

    // axis width default and fixed field widths
    localparam int AXIS_BITS_DEF = 16;
    localparam int MAG_OUT_W     = 16;
    localparam int THR_W         = 17;
    localparam int TICK_CFG_W    = 16;
    localparam int TIME_W        = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 17;

    // register reset values
    localparam logic [THR_W-1:0]      THR_RST       = 17'd4175;
    localparam logic [TICK_CFG_W-1:0] HOLDOFF_RST   = 16'd50;
    localparam logic [TICK_CFG_W-1:0] INDICATOR_RST = 16'd500;
    localparam logic [TICK_CFG_W-1:0] POST_RST      = 16'd400;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_HOLDOFF   = 2'd1,
        CFG_INDICATOR = 2'd2,
        CFG_POST      = 2'd3
    } t_cfg_idx;

    // magnitude engine sequencer
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SQUARE,
        ENG_ROOT,
        ENG_DONE
    } t_eng_state;

    // top level sequencer
    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_BUSY,
        TOP_EMIT
    } t_top_state;

    // engine status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_status;

endpackage

/* rtl/core/ait_ifs.sv */
// valid/ready channel interfaces for samples and trigger results
`timescale 1ns / 1ps

interface ait_in_if #(
    parameter int AXIS_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [AXIS_BITS-1:0] accel_x;
    logic signed [AXIS_BITS-1:0] accel_y;
    logic signed [AXIS_BITS-1:0] accel_z;
    logic [31:0]                 sample_time;

    modport source (output valid, accel_x, accel_y, accel_z, sample_time, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, sample_time, output ready);
endinterface

interface ait_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] magnitude;
    logic        impact;
    logic        indicator_on;
    logic        capture_done;

    modport source (output valid, magnitude, impact, indicator_on, capture_done,
                    input ready);
    modport sink   (input valid, magnitude, impact, indicator_on, capture_done,
                    output ready);
endinterface

/* rtl/core/ait_engine.sv */
// iterative magnitude engine: shared squarer then one root digit per cycle
`timescale 1ns / 1ps

module ait_engine
    import ait_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [AXIS_BITS-1:0] i_axis_x,
    input  logic signed [AXIS_BITS-1:0] i_axis_y,
    input  logic signed [AXIS_BITS-1:0] i_axis_z,
    output t_eng_status                 o_status,
    output logic [AXIS_BITS-1:0]        o_mag
);

    localparam int SUM_W = 2 * AXIS_BITS;

    t_eng_state                  r_state, n_state;
    logic signed [AXIS_BITS-1:0] r_ax, r_ay, r_az;
    logic [1:0]                  r_step;
    logic [SUM_W-1:0]            r_prod, r_rem, r_root, r_bit;

    logic signed [AXIS_BITS-1:0] w_sel;
    logic signed [SUM_W-1:0]     w_sq;
    logic [SUM_W-1:0]            w_trial;

    // axis select and shared squarer
    always_comb begin
        case (r_step)
            2'd0:    w_sel = r_ax;
            2'd1:    w_sel = r_ay;
            default: w_sel = r_az;
        endcase
        w_sq    = SUM_W'(w_sel) * SUM_W'(w_sel);
        w_trial = r_root + r_bit;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ENG_IDLE:   if (i_start) n_state = ENG_SQUARE;
            ENG_SQUARE: if (r_step == 2'd3) n_state = ENG_ROOT;
            ENG_ROOT:   if (r_bit[0]) n_state = ENG_DONE;
            ENG_DONE:   n_state = ENG_IDLE;
            default:    n_state = ENG_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath: square and accumulate, then restoring root
    always_ff @(posedge i_clk) begin
        case (r_state)
            ENG_IDLE: begin
                if (i_start) begin
                    r_ax   <= i_axis_x;
                    r_ay   <= i_axis_y;
                    r_az   <= i_axis_z;
                    r_step <= 2'd0;
                    r_rem  <= '0;
                end
            end
            ENG_SQUARE: begin
                r_prod <= $unsigned(w_sq);
                if (r_step != 2'd0) r_rem <= r_rem + r_prod;
                r_step <= r_step + 2'd1;
                r_root <= '0;
                r_bit  <= SUM_W'(1) << (SUM_W - 2);
            end
            ENG_ROOT: begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: begin
            end
        endcase
    end

    assign o_status.busy = (r_state != ENG_IDLE);
    assign o_status.done = (r_state == ENG_DONE);
    assign o_mag         = r_root[AXIS_BITS-1:0];

endmodule

/* rtl/core/accel_impact_trigger_top.sv */
// accelerometer impact trigger: magnitude, change test, holdoff and capture count
// sequence: the three axes are squared and summed on the shared squarer, the root is formed
//   digit by digit, then the decision is registered into the output register
// flow: a new sample is accepted only once the previous one has been emitted; the next sample is taken
//   while a result waits in the output register
// reset: synchronous active low; control registers return to their defaults, first sample pending
`timescale 1ns / 1ps

module accel_impact_trigger_top
    import ait_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ait_in_if.sink                i_in,
    ait_out_if.source             o_out
);

    localparam int MAG_W = AXIS_BITS;
    localparam int CMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;

    t_top_state              r_state, n_state;
    t_eng_status             w_eng_status;
    logic [MAG_W-1:0]        w_mag;
    logic                    w_start, w_emit;

    // configuration registers
    logic [THR_W-1:0]        r_thr;
    logic [TICK_CFG_W-1:0]   r_holdoff, r_ind_ticks, r_post_samples;

    // detector state
    logic [MAG_W-1:0]        r_prev;
    logic                    r_first, r_armed;
    logic [TIME_W-1:0]       r_last, r_time;
    logic [TICK_CFG_W-1:0]   r_post_cnt;

    // output register
    logic                    r_out_valid;
    logic [MAG_OUT_W-1:0]    r_out_mag;
    logic                    r_out_impact, r_out_ind, r_out_done;

    // decision next values
    logic [MAG_W-1:0]        w_change;
    logic                    n_impact, n_ind, n_done, n_armed;
    logic [TIME_W-1:0]       n_last;
    logic [TICK_CFG_W-1:0]   n_post_cnt, w_cnt_inc;
    logic                    w_armed_any;

    // shared magnitude engine
    ait_engine #(
        .AXIS_BITS (AXIS_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_axis_x (i_in.accel_x),
        .i_axis_y (i_in.accel_y),
        .i_axis_z (i_in.accel_z),
        .o_status (w_eng_status),
        .o_mag    (w_mag)
    );

    // handshake
    assign i_in.ready = (r_state == TOP_IDLE);
    assign w_start    = (r_state == TOP_IDLE) && i_in.valid;
    assign w_emit     = (r_state == TOP_EMIT) && (!r_out_valid || o_out.ready);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TOP_IDLE: if (i_in.valid) n_state = TOP_BUSY;
            TOP_BUSY: if (w_eng_status.done) n_state = TOP_EMIT;
            TOP_EMIT: if (w_emit) n_state = TOP_IDLE;
            default:  n_state = TOP_IDLE;
        endcase
    end

    // impact decision, indicator and post-trigger count
    always_comb begin
        w_change    = (w_mag > r_prev) ? (w_mag - r_prev) : (r_prev - w_mag);
        n_impact    = !r_first
                      && (CMP_W'(w_change) > CMP_W'(r_thr))
                      && ((r_time - r_last) > TIME_W'(r_holdoff));
        n_last      = n_impact ? r_time : r_last;
        n_ind       = (r_time - n_last) < TIME_W'(r_ind_ticks);
        w_armed_any = r_armed || n_impact;
        w_cnt_inc   = r_post_cnt + TICK_CFG_W'(1);
        n_done      = w_armed_any && (w_cnt_inc >= r_post_samples);
        n_armed     = w_armed_any && !n_done;
        if (!w_armed_any) begin
            n_post_cnt = r_post_cnt;
        end else if (n_done) begin
            n_post_cnt = '0;
        end else begin
            n_post_cnt = w_cnt_inc;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= TOP_IDLE;
            r_thr          <= THR_RST;
            r_holdoff      <= HOLDOFF_RST;
            r_ind_ticks    <= INDICATOR_RST;
            r_post_samples <= POST_RST;
            r_prev         <= '0;
            r_first        <= 1'b1;
            r_last         <= '0;
            r_armed        <= 1'b0;
            r_post_cnt     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            // register writes
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_THRESHOLD: r_thr          <= i_cfg_data;
                    CFG_HOLDOFF:   r_holdoff      <= i_cfg_data[TICK_CFG_W-1:0];
                    CFG_INDICATOR: r_ind_ticks    <= i_cfg_data[TICK_CFG_W-1:0];
                    CFG_POST:      r_post_samples <= i_cfg_data[TICK_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
            // detector state update at result time
            if (w_emit) begin
                r_prev     <= w_mag;
                r_first    <= 1'b0;
                r_last     <= n_last;
                r_armed    <= n_armed;
                r_post_cnt <= n_post_cnt;
            end
            // output valid
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_start) r_time <= i_in.sample_time;
        if (w_emit) begin
            r_out_mag    <= MAG_OUT_W'(w_mag);
            r_out_impact <= n_impact;
            r_out_ind    <= n_ind;
            r_out_done   <= n_done;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.magnitude    = r_out_mag;
    assign o_out.impact       = r_out_impact;
    assign o_out.indicator_on = r_out_ind;
    assign o_out.capture_done = r_out_done;

`ifndef SYNTHESIS
    // engine only started when it is free
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_eng_status.busy)
        else $error("engine started while busy");

    // engine finishes only while the sequencer waits for it
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eng_status.done |-> (r_state == TOP_BUSY))
        else $error("engine done outside busy state");

    // an impact records the sample time as last impact
    a_impact_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && n_impact) |=> (r_last == $past(r_time)))
        else $error("last impact time not updated");

    // capture done disarms the counter and clears it
    a_done_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && n_done) |=> (!r_armed && r_post_cnt == '0))
        else $error("capture done left counter armed");
`endif

endmodule

/* sim/accel_impact_trigger_top_test.sv */
// self-checking testbench for the accelerometer impact trigger
`timescale 1ns / 1ps

module accel_impact_trigger_top_test;
    import ait_pkg::*;

    localparam int SCRIPT_ROWS    = 18;
    localparam int POST_ZERO_ROW  = 12;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_SAMPLES  = 80;
    localparam int SETTLE_CYCLES  = 30;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 400;
    localparam int LONG_HOLD_AT   = 120;
    localparam int STALL_LIMIT    = 5000;
    localparam int PRINT_LIMIT    = 50;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [31:0] t;
    } t_sample;

    typedef struct packed {
        logic [15:0] magnitude;
        logic        impact;
        logic        indicator_on;
        logic        capture_done;
    } t_trig_result;

    typedef struct packed {
        logic [THR_W-1:0]      thr;
        logic [TICK_CFG_W-1:0] hold;
        logic [TICK_CFG_W-1:0] ind;
        logic [TICK_CFG_W-1:0] post;
    } t_reg_set;

    // typed = 1 means the listed result is checked as written
    typedef struct packed {
        logic        typed;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [31:0] t;
        logic [15:0] mag;
        logic        imp;
        logic        ind;
        logic        done;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ait_in_if #(.AXIS_BITS(AXIS_BITS_DEF)) in_if ();
    ait_out_if out_if ();

    accel_impact_trigger_top #(.AXIS_BITS(AXIS_BITS_DEF)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #5 i_clk = ~i_clk;

    // register copies kept by the predictor
    logic [THR_W-1:0]      thr_copy  = THR_RST;
    logic [TICK_CFG_W-1:0] hold_copy = HOLDOFF_RST;
    logic [TICK_CFG_W-1:0] ind_copy  = INDICATOR_RST;
    logic [TICK_CFG_W-1:0] post_copy = POST_RST;

    // trigger state kept by the predictor
    logic [16:0] prev_mag       = '0;
    logic        awaiting_first = 1'b1;
    logic [31:0] last_hit_tick  = '0;
    logic        window_open    = 1'b0;
    logic [15:0] window_count   = '0;

    t_trig_result pending_results[$];
    int unsigned  mismatch_count = 0;
    int unsigned  samples_sent   = 0;
    int unsigned  results_seen   = 0;
    int unsigned  hit_total      = 0;
    int unsigned  capture_total  = 0;
    int unsigned  settings_used  = 1;
    int unsigned  burst_left     = 0;
    logic [31:0]  tick_cursor    = '0;

    // directed samples; negative axes written as two's complement
    t_script_row shock_script [0:SCRIPT_ROWS-1] = '{
        // first sample after reset, indicator on before any impact
        '{1'b1, 16'd0, 16'd0, 16'd0, 32'd100, 16'd0, 1'b0, 1'b1, 1'b0},
        '{1'b1, 16'd3, 16'd4, 16'd0, 32'd600, 16'd5, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'h7FFF, 16'd0, 16'd0, 32'd700, 16'd32767, 1'b1, 1'b1, 1'b0},
        // full negative on all axes, inside the holdoff
        '{1'b0, 16'h8000, 16'h8000, 16'h8000, 32'd720, 16'd0, 1'b0, 1'b0, 1'b0},
        // impact again while the post count is running
        '{1'b0, 16'd0, 16'd0, 16'd0, 32'd771, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd800, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'h5555, 16'hAAAA, 16'h0F0F, 32'hFFFF_FFF0, 16'd0, 1'b0, 1'b0, 1'b0},
        // tick counter wraps
        '{1'b0, 16'd0, 16'd0, 16'd0, 32'h0000_0010, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'h8000, 16'd0, 16'd0, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0, 16'h7FFF, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'h8000, 32'h8000_0000, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd100, 16'hFF9C, 16'd50, 32'h8000_0001, 16'd0, 1'b0, 1'b0, 1'b0},
        // post count of zero: capture on the impact sample itself
        '{1'b0, 16'd0, 16'd0, 16'd0, 32'd5, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd2000, 16'd0, 16'd0, 32'd6, 16'd0, 1'b0, 1'b0, 1'b0},
        // zero elapsed ticks never beat a zero holdoff
        '{1'b0, 16'd0, 16'd0, 16'd0, 32'd6, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 32'd7, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0, 16'd3000, 16'd0, 32'd7, 16'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'h8000, 16'h8000, 16'h8000, 32'd8, 16'd0, 1'b0, 1'b0, 1'b0}
    };

    // magnitude, change test, holdoff, indicator and post count for one sample
    function automatic t_trig_result predict_trigger(input t_sample s);
        t_trig_result r;
        longint       energy;
        logic [16:0]  root;
        logic [16:0]  trial;
        logic [16:0]  swing;
        logic [31:0]  elapsed;
        energy = longint'($signed(s.x)) * longint'($signed(s.x))
               + longint'($signed(s.y)) * longint'($signed(s.y))
               + longint'($signed(s.z)) * longint'($signed(s.z));
        // floor root, one bit at a time from the top
        root = '0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (17'd1 << b);
            if (longint'(trial) * longint'(trial) <= energy)
                root = trial;
        end
        swing = (root > prev_mag) ? root - prev_mag : prev_mag - root;
        r = '0;
        elapsed = s.t - last_hit_tick;
        if (awaiting_first) begin
            awaiting_first = 1'b0;
        end else if (swing > thr_copy && elapsed > {16'd0, hold_copy}) begin
            last_hit_tick = s.t;
            r.impact = 1'b1;
            window_open = 1'b1;
            hit_total++;
        end
        prev_mag = root;
        elapsed = s.t - last_hit_tick;
        r.indicator_on = (elapsed < {16'd0, ind_copy});
        if (window_open) begin
            window_count = window_count + 16'd1;
            if (window_count >= post_copy) begin
                r.capture_done = 1'b1;
                window_count = '0;
                window_open = 1'b0;
                capture_total++;
            end
        end
        r.magnitude = root[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch on result %0d: %s got %0d want %0d",
                     results_seen, field, got, want);
        mismatch_count++;
    endtask

    // one register write, mirrored into the predictor copy
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_THRESHOLD: thr_copy  = value[THR_W-1:0];
            CFG_HOLDOFF:   hold_copy = value[TICK_CFG_W-1:0];
            CFG_INDICATOR: ind_copy  = value[TICK_CFG_W-1:0];
            CFG_POST:      post_copy = value[TICK_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // drain all results, let the block settle, then load a new setting
    task automatic apply_settings(input t_reg_set rs);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_THRESHOLD, rs.thr);
        write_reg(CFG_HOLDOFF,   {1'b0, rs.hold});
        write_reg(CFG_INDICATOR, {1'b0, rs.ind});
        write_reg(CFG_POST,      {1'b0, rs.post});
        i_cfg_we <= 1'b0;
        burst_left = 0;
        settings_used++;
    endtask

    // offer one sample in bursts with random gaps, predict on acceptance
    task automatic offer_sample(input t_sample s, input t_script_row row);
        int unsigned  gap;
        t_trig_result predicted;
        t_trig_result typed_result;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid       <= 1'b1;
        in_if.accel_x     <= s.x;
        in_if.accel_y     <= s.y;
        in_if.accel_z     <= s.z;
        in_if.sample_time <= s.t;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        predicted = predict_trigger(s);
        typed_result = '{row.mag, row.imp, row.ind, row.done};
        pending_results.push_back(row.typed ? typed_result : predicted);
        samples_sent++;
    endtask

    function automatic logic [15:0] pick_axis(input bit shock);
        int v;
        v = shock ? $urandom_range(0, 32767) : $urandom_range(0, 1500);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return 16'(v);
    endfunction

    // mostly quiet/shock sequences on a rising tick, some raw noise
    function automatic t_sample make_sample();
        t_sample     s;
        int unsigned kind;
        bit          shock;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            s.x = 16'($urandom);
            s.y = 16'($urandom);
            s.z = 16'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                s.t = $urandom;
            end else begin
                tick_cursor = tick_cursor + $urandom_range(0, 200);
                s.t = tick_cursor;
            end
        end else begin
            shock = (kind >= 6);
            tick_cursor = tick_cursor + $urandom_range(0, 120);
            s.t = tick_cursor;
            s.x = pick_axis(shock);
            s.y = pick_axis(shock);
            s.z = pick_axis(shock);
        end
        return s;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_trig_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", out_if.magnitude, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_if.magnitude !== want.magnitude)
                    report_mismatch("magnitude", out_if.magnitude, want.magnitude);
                if (out_if.impact !== want.impact)
                    report_mismatch("impact", out_if.impact, want.impact);
                if (out_if.indicator_on !== want.indicator_on)
                    report_mismatch("indicator_on", out_if.indicator_on, want.indicator_on);
                if (out_if.capture_done !== want.capture_done)
                    report_mismatch("capture_done", out_if.capture_done, want.capture_done);
            end
            results_seen++;
        end
    end

    // receiver: rotating ready patterns, one long hold-off
    initial begin : receiver
        logic [15:0] pattern;
        int unsigned pos;
        int unsigned span;
        int unsigned hold_left;
        bit          long_hold_done;
        logic        next_ready;
        pattern = '1;
        pos = 0;
        span = 0;
        hold_left = 0;
        long_hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                next_ready = 1'b0;
            end else begin
                if (span == 0) begin
                    pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
                    span = $urandom_range(8, 64);
                end
                span--;
                next_ready = pattern[pos];
                pos = (pos + 1) % 16;
            end
            out_if.ready <= next_ready;
        end
    end

    // watchdog on cycles without any transaction
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // stimulus: reset, directed samples, then random phases
    initial begin : stimulus
        t_reg_set    plan;
        t_script_row blank;
        blank = '0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_THRESHOLD;
        i_cfg_data        <= '0;
        in_if.valid       <= 1'b0;
        in_if.accel_x     <= '0;
        in_if.accel_y     <= '0;
        in_if.accel_z     <= '0;
        in_if.sample_time <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            if (r == POST_ZERO_ROW)
                apply_settings('{17'd1000, 16'd0, 16'hFFFF, 16'd0});
            offer_sample('{shock_script[r].x, shock_script[r].y, shock_script[r].z,
                           shock_script[r].t}, shock_script[r]);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: plan = '{17'd0, 16'd0, 16'hFFFF, 16'd1};
                1: plan = '{17'h1FFFF, 16'hFFFF, 16'd0, 16'hFFFF};
                default: begin
                    plan.thr  = 17'($urandom_range(500, 6000));
                    plan.hold = 16'($urandom_range(0, 120));
                    plan.ind  = 16'($urandom_range(0, 800));
                    plan.post = (p == 2) ? 16'd0 : 16'($urandom_range(1, 24));
                end
            endcase
            apply_settings(plan);
            tick_cursor = p[0] ? 32'hFFFF_F800 : $urandom;
            for (int n = 0; n < PHASE_SAMPLES; n++)
                offer_sample(make_sample(), blank);
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over", pending_results.size(), 0);

        $display("covered %0d samples and %0d results under %0d register settings",
                 samples_sent, results_seen, settings_used);
        $display("predicted %0d impacts and %0d completed capture windows",
                 hit_total, capture_total);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* accel_impact_trigger_top.f */
rtl/core/ait_pkg.sv
rtl/core/ait_ifs.sv
rtl/core/ait_engine.sv
rtl/core/accel_impact_trigger_top.sv
sim/accel_impact_trigger_top_test.sv
